// ----- hdl/sem_pkg.sv -----
// shared widths, register codes and control structs for the sobel edge magnitude block
package sem_pkg;

  localparam int unsigned PIX_W         = 8;
  localparam int unsigned COORD_W       = 12;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned GRAD_W        = 11;
  localparam int unsigned SUM_W         = 21;
  localparam int unsigned DEF_MAX_WIDTH = 4096;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned MIN_DIM       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

  localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;       // latch the pixel and read the line store
    logic win;        // shift the window, write back, advance position
    logic grad;       // register gx and gy
    logic sqr;        // register the squared sum, arm the root
    logic root_step;  // one bit of the square root
    logic load_out;   // move the result into the output register
  } sem_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic emit;       // the current position completes an interior window
    logic root_last;  // the root is on its last bit
  } sem_sts_t;

endpackage

// ----- hdl/sem_in_if.sv -----
// pixel input channel
interface sem_in_if import sem_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

// ----- hdl/sem_out_if.sv -----
// edge magnitude result channel
interface sem_out_if import sem_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   edge_magnitude;
  logic [COORD_W-1:0] centre_row;
  logic [COORD_W-1:0] centre_column;
  logic               frame_last;

  modport source (output valid, output edge_magnitude, output centre_row,
                  output centre_column, output frame_last, input ready);
  modport sink (input valid, input edge_magnitude, input centre_row,
                input centre_column, input frame_last, output ready);
endinterface

// ----- hdl/sem_dp.sv -----
// datapath: config registers, line store, window, gradient, square root, output register
module sem_dp import sem_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [PIX_W-1:0]     pixel_value,
  input  sem_cmd_t             cmd,
  output sem_sts_t             sts,
  output logic [PIX_W-1:0]     edge_magnitude,
  output logic [COORD_W-1:0]   centre_row,
  output logic [COORD_W-1:0]   centre_column,
  output logic                 frame_last
);

  localparam int unsigned AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CMP_W = 18;
  localparam logic [CMP_W-1:0] MAXW_CMP = CMP_W'(MAX_WIDTH);

  logic [CFG_W-1:0]   width_r, height_r;
  logic [CFG_W-1:0]   w_eff, h_eff;
  logic [COORD_W-1:0] row_r;
  logic [CFG_W-1:0]   col_r;
  logic [PIX_W-1:0]   px_r;
  logic [2*PIX_W-1:0] rd_r;
  logic [PIX_W-1:0]   win_r [9];
  logic [PIX_W-1:0]   top_px, mid_px;
  logic [2*PIX_W-1:0] wr_word;
  logic [AW-1:0]      addr;
  logic [COORD_W-1:0] pend_row_r, pend_col_r;
  logic               pend_last_r;
  logic               at_last;
  logic               col_wrap, row_wrap;

  logic [PIX_W+1:0]          sum_l, sum_r, sum_t, sum_b;
  logic signed [GRAD_W-1:0]  gx_nxt, gy_nxt, gx_r, gy_r;
  logic signed [2*GRAD_W-1:0] sqx, sqy;
  logic [SUM_W-1:0]          sqsum_r;
  logic [PIX_W-1:0]          root_r, mask_r, root_try;
  logic [2*PIX_W-1:0]        try_sq;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

  // effective frame size, clamped
  always_comb begin
    if (width_r < CFG_W'(MIN_DIM)) begin
      w_eff = CFG_W'(MIN_DIM);
    end else if (CMP_W'(width_r) > MAXW_CMP) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r < CFG_W'(MIN_DIM)) begin
      h_eff = CFG_W'(MIN_DIM);
    end else if (height_r > CFG_W'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
      endcase
    end
  end

  assign addr = AW'(col_r);

  // bank chosen by row parity: the current bank holds row r-2, the other row r-1
  assign top_px  = row_r[0] ? rd_r[2*PIX_W-1:PIX_W] : rd_r[PIX_W-1:0];
  assign mid_px  = row_r[0] ? rd_r[PIX_W-1:0] : rd_r[2*PIX_W-1:PIX_W];
  assign wr_word = row_r[0] ? {px_r, mid_px} : {mid_px, px_r};

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd_r <= line_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win) begin
      line_mem[addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      px_r <= pixel_value;
    end
  end

  assign sts.emit = (row_r >= COORD_W'(2)) && (col_r >= CFG_W'(2));
  assign at_last  = ({1'b0, row_r} == h_eff - CFG_W'(1)) && (col_r == w_eff - CFG_W'(1));
  assign col_wrap = ({1'b0, col_r} + (CFG_W+1)'(1)) >= {1'b0, w_eff};
  assign row_wrap = ({1'b0, row_r} + CFG_W'(1)) >= h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      row_r <= '0;
      col_r <= '0;
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.win) begin
      for (int k = 0; k < 3; k++) begin
        win_r[3*k]   <= win_r[3*k+1];
        win_r[3*k+1] <= win_r[3*k+2];
      end
      win_r[2] <= top_px;
      win_r[5] <= mid_px;
      win_r[8] <= px_r;
      if (col_wrap) begin
        col_r <= '0;
        row_r <= row_wrap ? '0 : row_r + COORD_W'(1);
      end else begin
        col_r <= col_r + CFG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.win) begin
      pend_row_r  <= row_r - COORD_W'(1);
      pend_col_r  <= COORD_W'(col_r - CFG_W'(1));
      pend_last_r <= at_last;
    end
  end

  // sobel kernels as column and row weighted sums
  assign sum_r = {2'b0, win_r[2]} + {1'b0, win_r[5], 1'b0} + {2'b0, win_r[8]};
  assign sum_l = {2'b0, win_r[0]} + {1'b0, win_r[3], 1'b0} + {2'b0, win_r[6]};
  assign sum_b = {2'b0, win_r[6]} + {1'b0, win_r[7], 1'b0} + {2'b0, win_r[8]};
  assign sum_t = {2'b0, win_r[0]} + {1'b0, win_r[1], 1'b0} + {2'b0, win_r[2]};
  assign gx_nxt = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
  assign gy_nxt = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
    end
  end

  assign sqx = gx_r * gx_r;
  assign sqy = gy_r * gy_r;

  // restoring square root, one bit per cycle from the top
  assign root_try = root_r | mask_r;
  assign try_sq   = root_try * root_try;
  assign sts.root_last = mask_r[0];

  always_ff @(posedge clk) begin
    if (cmd.sqr) begin
      sqsum_r <= SUM_W'(sqx[2*GRAD_W-3:0]) + SUM_W'(sqy[2*GRAD_W-3:0]);
      root_r  <= '0;
      mask_r  <= {1'b1, {(PIX_W-1){1'b0}}};
    end else if (cmd.root_step) begin
      if (try_sq <= sqsum_r[2*PIX_W-1:0]) begin
        root_r <= root_try;
      end
      mask_r <= mask_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      edge_magnitude <= (|sqsum_r[SUM_W-1:2*PIX_W]) ? MAG_SAT : root_r;
      centre_row     <= pend_row_r;
      centre_column  <= pend_col_r;
      frame_last     <= pend_last_r;
    end
  end

  a_root_mask: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.root_step |-> $onehot(mask_r))
    else $error("root step with a bad bit mask");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (row_r == '0) && (col_r == '0))
    else $error("register write did not restart the frame");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r < w_eff) && ({1'b0, row_r} < h_eff))
    else $error("position outside the frame");

endmodule

// ----- hdl/sem_ctrl.sv -----
// controller: sequences one pixel through the datapath and owns both handshakes
module sem_ctrl import sem_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  sem_sts_t sts,
  output sem_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_WIN  = 6'b000010,
    ST_GRAD = 6'b000100,
    ST_SQR  = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_HOLD = 6'b100000
  } sem_state_t;

  sem_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_WIN;
        end
      end
      ST_WIN: begin
        cmd.win   = 1'b1;
        state_nxt = sts.emit ? ST_GRAD : ST_IDLE;
      end
      ST_GRAD: begin
        cmd.grad  = 1'b1;
        state_nxt = ST_SQR;
      end
      ST_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // wait for the output register to drain
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_take_to_win: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_WIN))
    else $error("accepted beat did not move to the window step");

  a_border_back: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WIN && !sts.emit) |=> (state_r == ST_IDLE))
    else $error("border pixel did not return to idle");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_HOLD))
    else $error("result raised outside the hand-over step");

endmodule

// ----- hdl/sobel_edge_magnitude.sv -----
// Sobel 3x3 edge magnitude over a raster-order 8-bit pixel stream. A border pixel
// passes through accept and window update; an interior pixel through accept, window
// update, gradient, squared sum, 8 square root steps and hand-over. The square root
// unit resolves one result bit per cycle, and hand-over waits for a free output slot.
// A finished result waits in the output register while the next pixel is taken. The
// line store holds two rows in one memory of MAX_WIDTH words and needs no clearing
// after reset. Writing either size register restarts the frame at row 0, column 0.
module sobel_edge_magnitude import sem_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  sem_in_if.sink               in_ch,
  sem_out_if.source            out_ch
);

  sem_cmd_t cmd;
  sem_sts_t sts;

  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sem_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .pixel_value    (in_ch.pixel_value),
    .cmd            (cmd),
    .sts            (sts),
    .edge_magnitude (out_ch.edge_magnitude),
    .centre_row     (out_ch.centre_row),
    .centre_column  (out_ch.centre_column),
    .frame_last     (out_ch.frame_last)
  );

endmodule

// ----- bench/tb_sobel_edge_magnitude.sv -----
// self-checking bench for the sobel edge magnitude block: random frames, sizes and idling
module tb_sobel_edge_magnitude;
  import sem_pkg::*;

  localparam int unsigned MAX_W          = DEF_MAX_WIDTH;
  localparam int          SETTLE_CYCLES  = 24;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_PIXELS  = 320;
  localparam int          MAX_REPORTS    = 40;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum {STYLE_UNIFORM, STYLE_EXTREME, STYLE_RAMP, STYLE_FLAT} pixel_style_t;

  typedef struct packed {
    logic [PIX_W-1:0]   magnitude;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic               last;
  } edge_result_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  sem_in_if  in_ch ();
  sem_out_if out_ch ();

  sobel_edge_magnitude uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // gradient predictor state
  logic [CFG_W-1:0] img_width;
  logic [CFG_W-1:0] img_height;
  logic [PIX_W-1:0] row_history [2][MAX_W];
  logic [PIX_W-1:0] win_px [9];
  int unsigned      row_pos;
  int unsigned      col_pos;

  logic [PIX_W-1:0] pixels_to_send [$];
  logic [PIX_W-1:0] directed_px [$];
  edge_result_t     awaited_edges [$];
  edge_result_t     head_edge;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int mismatch_count;
  int pixels_taken;
  int edges_checked;
  int size_writes;
  int random_queued;
  int quiet_cycles;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic restart_frame_model();
    foreach (win_px[k]) win_px[k] = '0;
    row_pos = 0;
    col_pos = 0;
  endtask

  // one accepted pixel: update the line history and window, queue a result for interior centres
  task automatic predict_edge(input logic [PIX_W-1:0] px);
    int unsigned  w, h, r, c, bank, k;
    int           gx, gy;
    int unsigned  sq, root, trial;
    logic [PIX_W-1:0] top_px, mid_px;
    edge_result_t res;
    w = clamp_dim(img_width, MAX_W);
    h = clamp_dim(img_height, MAX_HEIGHT);
    r = row_pos;
    c = col_pos;
    bank = r & 1;
    top_px = row_history[bank][c];
    mid_px = row_history[bank ^ 1][c];
    row_history[bank][c] = px;
    for (k = 0; k < 3; k++) begin
      win_px[3*k]   = win_px[3*k+1];
      win_px[3*k+1] = win_px[3*k+2];
    end
    win_px[2] = top_px;
    win_px[5] = mid_px;
    win_px[8] = px;
    if (r >= 2 && c >= 2) begin
      gx = (int'(win_px[2]) + 2 * int'(win_px[5]) + int'(win_px[8]))
         - (int'(win_px[0]) + 2 * int'(win_px[3]) + int'(win_px[6]));
      gy = (int'(win_px[6]) + 2 * int'(win_px[7]) + int'(win_px[8]))
         - (int'(win_px[0]) + 2 * int'(win_px[1]) + int'(win_px[2]));
      sq = gx * gx + gy * gy;
      if (sq >= 65536) begin
        root = MAG_SAT;
      end else begin
        root = 0;
        for (trial = 128; trial != 0; trial = trial >> 1)
          if ((root | trial) * (root | trial) <= sq) root = root | trial;
      end
      res.magnitude = root[PIX_W-1:0];
      res.row       = COORD_W'(r - 1);
      res.column    = COORD_W'(c - 1);
      res.last      = (r == h - 1) && (c == w - 1);
      awaited_edges.push_back(res);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
  endtask

  // only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    if (idx == REG_IMAGE_WIDTH) img_width = CFG_W'(val);
    else img_height = CFG_W'(val);
    restart_frame_model();
    size_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 76;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 76;
      end
      default: begin
        send_idle_pct = 35;
        recv_stall_pct = 35;
      end
    endcase
  endtask

  task automatic queue_pixels(input int count, input pixel_style_t style);
    int k;
    @(negedge clk);
    for (k = 0; k < count; k++) begin
      case (style)
        STYLE_UNIFORM: pixels_to_send.push_back(PIX_W'($urandom_range(0, 255)));
        STYLE_EXTREME: pixels_to_send.push_back($urandom_range(0, 1) ? {PIX_W{1'b1}} : '0);
        STYLE_RAMP:    pixels_to_send.push_back(PIX_W'(k * 11 + $urandom_range(0, 6)));
        default:       pixels_to_send.push_back(PIX_W'($urandom_range(118, 126)));
      endcase
    end
  endtask

  // border pixels give nothing back, so allow the block to finish its last one
  task automatic wait_drained();
    do @(negedge clk);
    while (pixels_to_send.size() != 0 || in_ch.valid || awaited_edges.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.pixel_value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_edge(in_ch.pixel_value);
        pixels_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pixels_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_ch.valid       <= 1'b1;
          in_ch.pixel_value <= pixels_to_send.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_edges.size() == 0) begin
          report_mismatch("beat with nothing outstanding", out_ch.edge_magnitude, -1);
        end else begin
          head_edge = awaited_edges.pop_front();
          if (out_ch.edge_magnitude !== head_edge.magnitude)
            report_mismatch("edge_magnitude", out_ch.edge_magnitude, head_edge.magnitude);
          if (out_ch.centre_row !== head_edge.row)
            report_mismatch("centre_row", out_ch.centre_row, head_edge.row);
          if (out_ch.centre_column !== head_edge.column)
            report_mismatch("centre_column", out_ch.centre_column, head_edge.column);
          if (out_ch.frame_last !== head_edge.last)
            report_mismatch("frame_last", out_ch.frame_last, head_edge.last);
          edges_checked++;
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    int phase;
    int n;
    int unsigned width_val;
    int unsigned height_val;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_IMAGE_WIDTH;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.pixel_value = '0;
    out_ch.ready      = 1'b0;
    hold_left         = 0;
    mismatch_count    = 0;
    pixels_taken      = 0;
    edges_checked     = 0;
    size_writes       = 0;
    random_queued     = 0;
    img_width         = RST_IMAGE_WIDTH;
    img_height        = RST_IMAGE_HEIGHT;
    restart_frame_model();
    set_idling(IDLE_NONE);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // sizes straight out of reset: part of the first row, nothing comes back
    queue_pixels(12, STYLE_UNIFORM);
    wait_drained();

    // 3x3 frames back to back: strong negative gradient, just under and just at saturation
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    directed_px = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0,
                    8'd0, 8'd0, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd127,
                    8'd0, 8'd0, 8'd128, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd128};
    @(negedge clk);
    foreach (directed_px[i]) pixels_to_send.push_back(directed_px[i]);
    wait_drained();

    // oversized width and zero height, both clamped: the first row only starts
    write_reg(REG_IMAGE_WIDTH, 8191);
    write_reg(REG_IMAGE_HEIGHT, 0);
    queue_pixels(20, STYLE_UNIFORM);
    wait_drained();

    // zero width and oversized height: narrow rows run past where a short frame would wrap
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 8191);
    queue_pixels(24, STYLE_EXTREME);
    wait_drained();

    for (phase = 0; random_queued < RANDOM_PIXELS || phase < 4; phase++) begin
      set_idling(idle_mode_t'(phase % 4));
      width_val  = (phase % 5 == 4) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      height_val = (phase % 7 == 5) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      // now and then only the height is written, which still restarts the frame
      if (phase % 3 != 2) write_reg(REG_IMAGE_WIDTH, width_val);
      write_reg(REG_IMAGE_HEIGHT, height_val);
      n = $urandom_range(10, 2 * clamp_dim(img_width, MAX_W)
                               * clamp_dim(img_height, MAX_HEIGHT) + 10);
      if (phase == 0) begin
        n = 150;
        queue_pixels(n, pixel_style_t'(phase % 4));
        hold_left = HOLD_CYCLES;
      end else if (phase == 1) begin
        queue_pixels(n / 2, pixel_style_t'(phase % 4));
        wait_drained();
        queue_pixels(n - n / 2, pixel_style_t'(phase % 4));
      end else begin
        queue_pixels(n, pixel_style_t'(phase % 4));
      end
      random_queued += n;
      wait_drained();
    end

    if (awaited_edges.size() != 0)
      report_mismatch("results never delivered", 0, awaited_edges.size());
    $display("%0d pixels accepted, %0d edge results checked", pixels_taken, edges_checked);
    $display("%0d size writes incl. clamped extremes, %0d random phases", size_writes, phase);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/sem_pkg.sv
hdl/sem_in_if.sv
hdl/sem_out_if.sv
hdl/sem_dp.sv
hdl/sem_ctrl.sv
hdl/sobel_edge_magnitude.sv
bench/tb_sobel_edge_magnitude.sv
